// ===== rtl/espmc_pkg.sv =====
// Package for the encoder speed PI motor controller.
// Shared constants, register indexes and the status struct. No dependencies.
package espmc_pkg;

    localparam int PosW  = 32;
    localparam int TimeW = 32;
    localparam int SpdW  = 18;
    localparam int DutyW = 8;
    localparam int DirW  = 2;
    localparam int OnW   = 10;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_KP    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KI    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ILIM  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_FLOOR = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CEIL  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_STOP  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_CPR   = 3'd6;

    localparam int InW  = PosW + TimeW + SpdW;
    localparam int InBytesW = ((InW + 7) / 8) * 8;
    localparam int OutW = SpdW + DutyW + DirW + 1 + 1 + OnW;
    localparam int OutBytesW = ((OutW + 7) / 8) * 8;

    // serial divider: 64-bit dividend, 40-bit divisor
    localparam int DivNW = 64;
    localparam int DivDW = 40;
    localparam int DivCntW = 7;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// ===== rtl/espmc_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on espmc_pkg.
module espmc_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [espmc_pkg::DivNW-1:0]        dividend,
    input  logic [espmc_pkg::DivDW-1:0]        divisor,
    output espmc_pkg::div_ctl_t                ctl,
    output logic [espmc_pkg::DivNW-1:0]        quotient
);
    import espmc_pkg::*;

    logic [DivNW-1:0]   q_reg, q_next;
    logic [DivDW:0]     r_reg, r_next;
    logic [DivDW-1:0]   d_reg, d_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic [DivDW+1:0]   trial;
    logic [DivDW:0]     shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[DivDW-1:0], q_reg[DivNW-1]};
        trial     = {1'b0, shifted} - {2'b00, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DivDW+1])
            begin
                r_next = trial[DivDW:0];
                q_next = {q_reg[DivNW-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[DivNW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DivCntW'(DivNW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quotient  = q_reg;
endmodule

// ===== rtl/espmc_mul.sv =====
// Shift-and-add serial multiplier, one multiplier bit per cycle.
// Depends on espmc_pkg.
module espmc_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] mcand,
    input  logic [23:0] mplier,
    output logic        done,
    output logic [63:0] product
);
    import espmc_pkg::*;

    logic [63:0] p_reg, p_next;
    logic [63:0] a_reg, a_next;
    logic [23:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        p_next    = p_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            p_next    = '0;
            a_next    = {24'd0, mcand};
            b_next    = mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                p_next = p_reg + a_reg;
            a_next   = {a_reg[62:0], 1'b0};
            b_next   = {1'b0, b_reg[23:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done    = done_reg;
    assign product = p_reg;
endmodule

// ===== rtl/encoder_speed_pi_motor_controller.sv =====
// Encoder speed PI motor controller, top level.
// Depends on espmc_pkg, espmc_div and espmc_mul.
//
// Usage:
//   s_axis carries one control tick per word: encoder position, timestamp and
//   target speed. m_axis returns one result word per tick. cfg writes one of
//   seven gain and limit registers by index; write only while idle.
//   Each tick runs a sequence on one shared serial multiplier and one serial
//   divider: delta*1e6, divide by elapsed, *960, divide by counts_per_rev,
//   kp*e, ki*I, then duty*1000 divided by 255 on a start. With zero elapsed
//   time the speed stage is skipped. The next tick is taken in the cycle
//   after the result is written. One tick at a time.
//   The result sits in an output register; a new tick is accepted while it
//   waits, but its result is not written until the register is free.
//   Reset loads register defaults, clears all state and empties the output.
//   A stalled receiver holds the result word unchanged.
module encoder_speed_pi_motor_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // encoder_position, time_us, target_rpm
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // measured_rpm, duty, drive_direction,
                                        // braking, start_pwm, first_on_time_us
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import espmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_D1, S_M2, S_D2, S_SPD, S_PI, S_MP, S_MI, S_DUTY,
        S_MON, S_DON, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] kp_reg, ki_reg, ilim_reg, cpr_reg;
    logic [7:0]  floor_reg, ceil_reg;
    logic [11:0] stop_reg;
    logic [31:0] ppos_reg, ptime_reg, elapsed_reg;
    logic signed [17:0] spd_reg, integ_reg, target_reg;
    logic signed [18:0] err_reg;
    logic [7:0]  duty_reg;
    logic [1:0]  dir_reg;
    logic        run_reg, neg_reg, brake_reg, start_reg;
    logic [9:0]  on_reg;
    logic [63:0] acc_reg;
    logic [39:0] out_reg;
    logic        ovalid_reg;

    logic        mul_start, mul_done, div_start;
    logic [39:0] mul_a;
    logic [23:0] mul_b;
    logic [63:0] mul_p, div_q;
    logic [63:0] div_n;
    logic [39:0] div_d;
    div_ctl_t    div_ctl;

    logic signed [31:0] delta_w;
    logic [31:0] mag_w;
    logic [17:0] tabs_w;
    logic signed [19:0] isum_w;
    logic signed [19:0] ilim_w;
    logic signed [18:0] err_w;
    logic [18:0] errabs_w;
    logic [63:0] accabs_w;
    logic [43:0] u_w;
    logic [7:0]  dsel_w;

    espmc_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start), .mcand(mul_a),
                     .mplier(mul_b), .done(mul_done), .product(mul_p));
    espmc_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
                     .divisor(div_d), .ctl(div_ctl), .quotient(div_q));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    assign delta_w  = $signed(s_axis_tdata[31:0] - ppos_reg);
    assign mag_w    = delta_w[31] ? 32'(-delta_w) : 32'(delta_w);
    assign tabs_w   = target_reg[17] ? 18'(-target_reg) : 18'(target_reg);
    assign err_w    = 19'(target_reg) - 19'(spd_reg);
    assign errabs_w = err_w[18] ? 19'(-err_w) : 19'(err_w);
    assign isum_w   = 20'(integ_reg) + 20'(err_w);
    assign ilim_w   = $signed({4'd0, ilim_reg});
    assign accabs_w = acc_reg[63] ? -acc_reg : acc_reg;
    assign u_w      = accabs_w[63:20];
    assign dsel_w   = (u_w < 44'(floor_reg)) ? floor_reg :
                      ((u_w > 44'(ceil_reg)) ? ceil_reg : u_w[7:0]);

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = acc_reg;
        div_d     = {8'd0, elapsed_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                mul_start = s_axis_tvalid && (s_axis_tdata[63:32] != ptime_reg);
                mul_a     = {8'd0, mag_w};
                mul_b     = 24'd1000000;
            end
            S_M1:
            begin
                div_start = mul_done;
                div_n     = mul_p;
            end
            S_D1:
            begin
                mul_start = div_ctl.done;
                mul_a     = (|div_q[63:40]) ? '1 : div_q[39:0];
                mul_b     = 24'd960;
            end
            S_M2:
            begin
                div_start = mul_done;
                div_n     = mul_p;
                div_d     = {24'd0, (cpr_reg == 16'd0) ? 16'd1 : cpr_reg};
            end
            S_PI:
            begin
                mul_start = 1'b1;
                mul_a     = {21'd0, errabs_w};
                mul_b     = {8'd0, kp_reg};
            end
            S_MP:
            begin
                mul_start = mul_done;
                mul_a     = 40'(integ_reg[17] ? 18'(-integ_reg) : 18'(integ_reg));
                mul_b     = {8'd0, ki_reg};
            end
            S_DUTY:
            begin
                mul_start = !run_reg;
                mul_a     = {32'd0, dsel_w};
                mul_b     = 24'd1000;
            end
            S_MON:
            begin
                div_start = mul_done;
                div_n     = mul_p;
                div_d     = 40'd255;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kp_reg     <= 16'd5243;
            ki_reg     <= 16'd5590;
            ilim_reg   <= 16'd48000;
            floor_reg  <= 8'd10;
            ceil_reg   <= 8'd245;
            stop_reg   <= 12'd16;
            cpr_reg    <= 16'd2184;
            ppos_reg   <= '0;
            ptime_reg  <= '0;
            spd_reg    <= '0;
            integ_reg  <= '0;
            duty_reg   <= '0;
            dir_reg    <= '0;
            run_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            elapsed_reg <= '0;
            target_reg <= '0;
            err_reg    <= '0;
            neg_reg    <= 1'b0;
            brake_reg  <= 1'b0;
            start_reg  <= 1'b0;
            on_reg     <= '0;
            acc_reg    <= '0;
            out_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_KP:    kp_reg    <= cfg_data;
                    REG_KI:    ki_reg    <= cfg_data;
                    REG_ILIM:  ilim_reg  <= cfg_data;
                    REG_FLOOR: floor_reg <= cfg_data[7:0];
                    REG_CEIL:  ceil_reg  <= cfg_data[7:0];
                    REG_STOP:  stop_reg  <= cfg_data[11:0];
                    REG_CPR:   cpr_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (ovalid_reg && m_axis_tready && (state_reg != S_OUT))
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ppos_reg    <= s_axis_tdata[31:0];
                        ptime_reg   <= s_axis_tdata[63:32];
                        elapsed_reg <= s_axis_tdata[63:32] - ptime_reg;
                        target_reg  <= $signed(s_axis_tdata[81:64]);
                        neg_reg     <= delta_w[31];
                        state_reg   <= (s_axis_tdata[63:32] != ptime_reg) ? S_M1 : S_PI;
                        brake_reg   <= 1'b0;
                        start_reg   <= 1'b0;
                        on_reg      <= '0;
                    end
                end
                S_M1: if (mul_done) state_reg <= S_D1;
                S_D1: if (div_ctl.done) state_reg <= S_M2;
                S_M2: if (mul_done) state_reg <= S_D2;
                S_D2:
                begin
                    if (div_ctl.done)
                    begin
                        acc_reg   <= div_q;
                        state_reg <= S_SPD;
                    end
                end
                S_SPD:
                begin
                    if (neg_reg)
                        spd_reg <= (acc_reg > 64'd131072) ? -18'sd131072 : 18'(-acc_reg);
                    else
                        spd_reg <= (acc_reg > 64'd131071) ? 18'sd131071 : 18'(acc_reg);
                    state_reg <= S_PI;
                end
                S_PI:
                begin
                    if (tabs_w < 18'(stop_reg))
                    begin
                        run_reg   <= 1'b0;
                        integ_reg <= '0;
                        dir_reg   <= '0;
                        brake_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        err_reg <= err_w;
                        if (isum_w > ilim_w)
                            integ_reg <= 18'(ilim_w);
                        else if (isum_w < -ilim_w)
                            integ_reg <= 18'(-ilim_w);
                        else
                            integ_reg <= 18'(isum_w);
                        state_reg <= S_MP;
                    end
                end
                S_MP:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= err_reg[18] ? -mul_p : mul_p;
                        state_reg <= S_MI;
                    end
                end
                S_MI:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_reg + (integ_reg[17] ? -mul_p : mul_p);
                        state_reg <= S_DUTY;
                    end
                end
                S_DUTY:
                begin
                    duty_reg  <= dsel_w;
                    dir_reg   <= target_reg[17] ? 2'b11 : ((target_reg != 0) ? 2'b01 : 2'b00);
                    start_reg <= !run_reg;
                    run_reg   <= 1'b1;
                    state_reg <= run_reg ? S_OUT : S_MON;
                end
                S_MON: if (mul_done) state_reg <= S_DON;
                S_DON:
                begin
                    if (div_ctl.done)
                    begin
                        on_reg    <= (div_q[9:0] < 10'd50) ? 10'd50 : div_q[9:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        out_reg    <= {on_reg, start_reg, brake_reg, dir_reg,
                                       duty_reg, spd_reg};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
